@@ design/stomp_fhp_pkg.sv @@
package stomp_fhp_pkg;

   // Parser phases, one-hot.
   typedef enum logic [8:0] {
      PH_START       = 9'b000000001,
      PH_COMMAND     = 9'b000000010,
      PH_COMMAND_LF  = 9'b000000100,
      PH_HDR_START   = 9'b000001000,
      PH_HDR_NAME    = 9'b000010000,
      PH_HDR_VALUE   = 9'b000100000,
      PH_HDR_CR      = 9'b001000000,
      PH_ALMOST_DONE = 9'b010000000,
      PH_DISCARD     = 9'b100000000
   } phase_type;

   typedef logic [1:0] event_type;
   localparam event_type EV_HEADER     = 2'd0;
   localparam event_type EV_HDRS_END   = 2'd1;
   localparam event_type EV_DISCONNECT = 2'd2;
   localparam event_type EV_INVALID    = 2'd3;

   typedef logic [3:0] command_type;
   localparam command_type CMD_NONE        = 4'd0;
   localparam command_type CMD_ACK         = 4'd2;
   localparam command_type CMD_SEND        = 4'd3;
   localparam command_type CMD_NACK        = 4'd4;
   localparam command_type CMD_BEGIN       = 4'd5;
   localparam command_type CMD_ABORT       = 4'd6;
   localparam command_type CMD_ERROR       = 4'd7;
   localparam command_type CMD_COMMIT      = 4'd8;
   localparam command_type CMD_CONNECT     = 4'd9;
   localparam command_type CMD_MESSAGE     = 4'd10;
   localparam command_type CMD_RECEIPT     = 4'd11;
   localparam command_type CMD_SUBSCRIBE   = 4'd12;
   localparam command_type CMD_CONNECTED   = 4'd13;
   localparam command_type CMD_DISCONNECT  = 4'd14;
   localparam command_type CMD_UNSUBSCRIBE = 4'd15;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_HYPHEN = 8'h2D;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_UP_A   = 8'h41;
   localparam logic [7:0] CH_UP_E   = 8'h45;
   localparam logic [7:0] CH_UP_Z   = 8'h5A;
   localparam logic [7:0] CH_LO_A   = 8'h61;
   localparam logic [7:0] CH_LO_Z   = 8'h7A;

   // Command words, padded with NUL to the longest word.
   localparam int CMD_TEXT_LEN = 11;
   localparam int CMD_ENTRIES  = 15;
   // Letter position taken without a range check, besides the first three.
   localparam int FREE_POS     = 8;

   typedef logic [7:0] cmd_text_type [CMD_TEXT_LEN];

   localparam cmd_text_type CMD_TEXT [CMD_ENTRIES] = '{
      '{"A","C","K",8'h0,8'h0,8'h0,8'h0,8'h0,8'h0,8'h0,8'h0},
      '{"N","A","C","K",8'h0,8'h0,8'h0,8'h0,8'h0,8'h0,8'h0},
      '{"S","E","N","D",8'h0,8'h0,8'h0,8'h0,8'h0,8'h0,8'h0},
      '{"S","T","O","M","P",8'h0,8'h0,8'h0,8'h0,8'h0,8'h0},
      '{"B","E","G","I","N",8'h0,8'h0,8'h0,8'h0,8'h0,8'h0},
      '{"A","B","O","R","T",8'h0,8'h0,8'h0,8'h0,8'h0,8'h0},
      '{"E","R","R","O","R",8'h0,8'h0,8'h0,8'h0,8'h0,8'h0},
      '{"C","O","M","M","I","T",8'h0,8'h0,8'h0,8'h0,8'h0},
      '{"C","O","N","N","E","C","T",8'h0,8'h0,8'h0,8'h0},
      '{"M","E","S","S","A","G","E",8'h0,8'h0,8'h0,8'h0},
      '{"R","E","C","E","I","P","T",8'h0,8'h0,8'h0,8'h0},
      '{"S","U","B","S","C","R","I","B","E",8'h0,8'h0},
      '{"C","O","N","N","E","C","T","E","D",8'h0,8'h0},
      '{"D","I","S","C","O","N","N","E","C","T",8'h0},
      '{"U","N","S","U","B","S","C","R","I","B","E"}
   };

   localparam logic [3:0] CMD_LEN [CMD_ENTRIES] = '{
      4'd3, 4'd4, 4'd4, 4'd5, 4'd5, 4'd5, 4'd5, 4'd6,
      4'd7, 4'd7, 4'd7, 4'd9, 4'd9, 4'd10, 4'd11
   };

   localparam command_type CMD_CODE [CMD_ENTRIES] = '{
      CMD_ACK, CMD_NACK, CMD_SEND, CMD_CONNECT, CMD_BEGIN, CMD_ABORT,
      CMD_ERROR, CMD_COMMIT, CMD_CONNECT, CMD_MESSAGE, CMD_RECEIPT,
      CMD_SUBSCRIBE, CMD_CONNECTED, CMD_DISCONNECT, CMD_UNSUBSCRIBE
   };

endpackage

@@ design/stomp_frame_header_parser_top.sv @@
// Channel   Direction  Handshake           Beat payload
// req_      in         req_valid/req_stall data_byte (8)
// rsp_      out        rsp_valid/rsp_stall event_kind, command_code, name_hash,
//                                          name_length, value_length, name_flagged
//
// One byte per cycle sustained, but for the stalls below. A byte waits in the input
// register, where the phase logic and the hash multiply-add by 31 decide the next
// state and at most one result beat, which is loaded into the output register.
// A byte that makes no result moves on even while a result beat is stalled;
// one that makes a result waits until the output register is free.
// Reset is synchronous and returns the parser to the start phase.
module stomp_frame_header_parser_top
   import stomp_fhp_pkg::*;
#(
   parameter int MAX_COMMAND_LEN = 11,
   parameter int HASH_BITS       = 32,
   parameter int NAME_LEN_BITS   = 12,
   parameter int VALUE_LEN_BITS  = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_data_byte,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_event_kind,
   output logic [3:0]                rsp_command_code,
   output logic [HASH_BITS-1:0]      rsp_name_hash,
   output logic [NAME_LEN_BITS-1:0]  rsp_name_length,
   output logic [VALUE_LEN_BITS-1:0] rsp_value_length,
   output logic                      rsp_name_flagged
);

   // The letter count runs one past the store so that overlong commands are seen.
   localparam int CNT_W = $clog2(MAX_COMMAND_LEN + 2);
   localparam logic [NAME_LEN_BITS-1:0]  NAME_MAX  = '1;
   localparam logic [VALUE_LEN_BITS-1:0] VALUE_MAX = '1;

   // Input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   // Parser state
   phase_type                 phase_ff, phase_in;
   logic [7:0]                letters_ff [MAX_COMMAND_LEN];
   logic [7:0]                letters_in [MAX_COMMAND_LEN];
   logic [CNT_W-1:0]          count_ff, count_in;
   command_type               cmd_ff, cmd_in;
   logic [HASH_BITS-1:0]      hash_ff, hash_in;
   logic [NAME_LEN_BITS-1:0]  name_ff, name_in;
   logic [VALUE_LEN_BITS-1:0] value_ff, value_in;
   logic                      bad_ff, bad_in;

   // Output register
   logic                      out_valid_ff, out_valid_in;
   event_type                 out_kind_ff;
   command_type               out_cmd_ff;
   logic [HASH_BITS-1:0]      out_hash_ff;
   logic [NAME_LEN_BITS-1:0]  out_name_ff;
   logic [VALUE_LEN_BITS-1:0] out_value_ff;
   logic                      out_flag_ff;

   logic        emit;
   event_type   emit_kind;
   logic        advance;
   command_type matched;
   logic        add_letter;
   logic [CNT_W-1:0] letter_pos;
   logic [7:0]  ch;
   logic        is_letter, in_range;
   logic [HASH_BITS-1:0] hash_step;

   assign ch        = in_byte_ff;
   assign is_letter = (ch >= CH_LO_A && ch <= CH_LO_Z) || (ch >= CH_UP_A && ch <= CH_UP_Z)
                      || ch == CH_HYPHEN;
   assign in_range  = ch >= CH_UP_A && ch <= CH_LO_Z;
   // hash * 31 + byte, wrapping.
   assign hash_step = (hash_ff << 5) - hash_ff + HASH_BITS'(ch);

   // Compare the gathered letters with every command word at once.
   always_comb begin
      logic hit;
      matched = CMD_NONE;
      for (int e = CMD_ENTRIES - 1; e >= 0; e--) begin
         hit = (count_ff == CNT_W'(CMD_LEN[e]));
         for (int k = 0; k < CMD_TEXT_LEN; k++) begin
            if (k < int'(CMD_LEN[e]) && letters_ff[k] != CMD_TEXT[e][k]) begin
               hit = 1'b0;
            end
         end
         if (hit) begin
            matched = CMD_CODE[e];
         end
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      cmd_in     = cmd_ff;
      hash_in    = hash_ff;
      name_in    = name_ff;
      value_in   = value_ff;
      bad_in     = bad_ff;
      emit       = 1'b0;
      emit_kind  = EV_INVALID;
      add_letter = 1'b0;

      unique case (phase_ff)
         PH_START: begin
            if (ch != CH_CR && ch != CH_LF) begin
               count_in   = '0;
               cmd_in     = CMD_NONE;
               phase_in   = PH_COMMAND;
               add_letter = 1'b1;
            end
         end
         PH_COMMAND: begin
            if (matched != CMD_NONE) begin
               cmd_in = matched;
               priority if (matched == CMD_DISCONNECT) begin
                  phase_in  = PH_START;
                  emit      = 1'b1;
                  emit_kind = EV_DISCONNECT;
               end else if (ch == CH_CR) begin
                  phase_in = PH_COMMAND_LF;
               end else if (ch == CH_LF) begin
                  phase_in = PH_HDR_START;
               end else if (ch == CH_UP_E && matched == CMD_CONNECT) begin
                  add_letter = 1'b1;
               end else begin
                  emit = 1'b1;
               end
            end else if (count_ff > CNT_W'(MAX_COMMAND_LEN)) begin
               emit = 1'b1;
            end else if (count_ff >= CNT_W'(3) && count_ff != CNT_W'(FREE_POS)
                         && !in_range) begin
               emit = 1'b1;
            end else begin
               add_letter = 1'b1;
            end
         end
         PH_COMMAND_LF: begin
            priority if (ch == CH_CR) begin
               phase_in = PH_COMMAND_LF;
            end else if (ch == CH_LF) begin
               phase_in = PH_HDR_START;
            end else begin
               emit = 1'b1;
            end
         end
         PH_HDR_START: begin
            bad_in = 1'b0;
            priority if (ch == CH_CR) begin
               phase_in = PH_ALMOST_DONE;
            end else if (ch == CH_LF) begin
               if (cmd_ff == CMD_SEND || cmd_ff == CMD_MESSAGE) begin
                  phase_in  = PH_START;
                  emit      = 1'b1;
                  emit_kind = EV_HDRS_END;
               end else begin
                  phase_in = PH_ALMOST_DONE;
               end
            end else if (ch == CH_NUL || ch == CH_COLON) begin
               emit = 1'b1;
            end else begin
               phase_in = PH_HDR_NAME;
               hash_in  = HASH_BITS'(ch);
               name_in  = NAME_LEN_BITS'(1);
               value_in = '0;
            end
         end
         PH_HDR_NAME: begin
            priority if (is_letter) begin
               hash_in = hash_step;
               if (name_ff != NAME_MAX) begin
                  name_in = name_ff + NAME_LEN_BITS'(1);
               end
            end else if (ch == CH_COLON) begin
               value_in = '0;
               phase_in = PH_HDR_VALUE;
            end else if (ch == CH_CR) begin
               value_in = '0;
               phase_in = PH_HDR_CR;
            end else if (ch == CH_LF) begin
               // A name ended by a bare LF is dropped without an event.
               phase_in = PH_HDR_START;
            end else if (ch == CH_NUL) begin
               emit = 1'b1;
            end else begin
               bad_in = 1'b1;
               if (name_ff != NAME_MAX) begin
                  name_in = name_ff + NAME_LEN_BITS'(1);
               end
            end
         end
         PH_HDR_VALUE: begin
            priority if (ch == CH_CR) begin
               phase_in = PH_HDR_CR;
            end else if (ch == CH_LF) begin
               phase_in  = PH_HDR_START;
               emit      = 1'b1;
               emit_kind = EV_HEADER;
            end else if (ch == CH_NUL) begin
               emit = 1'b1;
            end else if (value_ff != VALUE_MAX) begin
               value_in = value_ff + VALUE_LEN_BITS'(1);
            end
         end
         PH_HDR_CR: begin
            priority if (ch == CH_LF) begin
               phase_in  = PH_HDR_START;
               emit      = 1'b1;
               emit_kind = EV_HEADER;
            end else if (ch == CH_CR) begin
               phase_in = PH_HDR_CR;
            end else begin
               emit = 1'b1;
            end
         end
         PH_ALMOST_DONE: begin
            priority if (ch == CH_CR || ch == CH_LF) begin
               if (cmd_ff == CMD_SEND || cmd_ff == CMD_MESSAGE) begin
                  phase_in  = PH_START;
                  emit      = 1'b1;
                  emit_kind = EV_HDRS_END;
               end
            end else if (ch == CH_NUL) begin
               phase_in  = PH_START;
               emit      = 1'b1;
               emit_kind = EV_HDRS_END;
            end else begin
               emit = 1'b1;
            end
         end
         PH_DISCARD: begin
            if (ch == CH_NUL) begin
               phase_in = PH_START;
            end
         end
         default: begin
            emit = 1'b1;
         end
      endcase

      // An invalid byte sends the parser to discard, unless it is the NUL itself.
      if (emit && emit_kind == EV_INVALID) begin
         phase_in = (ch == CH_NUL) ? PH_START : PH_DISCARD;
      end

      // A new command starts its letters at slot zero, so the slot follows the cleared count.
      letter_pos = count_in;
      if (add_letter && count_in <= CNT_W'(MAX_COMMAND_LEN)) begin
         count_in = count_in + CNT_W'(1);
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_COMMAND_LEN; i++) begin
         letters_in[i] = letters_ff[i];
         if (add_letter && letter_pos == CNT_W'(i)) begin
            letters_in[i] = ch;
         end
      end
   end

   // A byte moves on unless it makes a beat while the output register is held.
   assign advance      = in_valid_ff && !(emit && out_valid_ff && rsp_stall);
   assign req_stall    = in_valid_ff && !advance;
   assign in_valid_in  = (req_valid && !req_stall) || (in_valid_ff && !advance);
   assign out_valid_in = (advance && emit) || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_START;
         count_ff     <= '0;
         cmd_ff       <= CMD_NONE;
         hash_ff      <= '0;
         name_ff      <= '0;
         value_ff     <= '0;
         bad_ff       <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            phase_ff <= phase_in;
            count_ff <= count_in;
            cmd_ff   <= cmd_in;
            hash_ff  <= hash_in;
            name_ff  <= name_in;
            value_ff <= value_in;
            bad_ff   <= bad_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_data_byte;
      end
      if (advance) begin
         letters_ff <= letters_in;
      end
      if (advance && emit) begin
         out_kind_ff <= emit_kind;
         out_cmd_ff  <= cmd_in;
         if (emit_kind == EV_HEADER) begin
            out_hash_ff  <= hash_ff;
            out_name_ff  <= name_ff;
            out_value_ff <= value_ff;
            out_flag_ff  <= bad_ff;
         end else begin
            out_hash_ff  <= '0;
            out_name_ff  <= '0;
            out_value_ff <= '0;
            out_flag_ff  <= 1'b0;
         end
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_event_kind   = out_kind_ff;
   assign rsp_command_code = out_cmd_ff;
   assign rsp_name_hash    = out_hash_ff;
   assign rsp_name_length  = out_name_ff;
   assign rsp_value_length = out_value_ff;
   assign rsp_name_flagged = out_flag_ff;

`ifndef SYNTH
   a_discard_silent: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && phase_ff == PH_DISCARD) |-> !emit)
      else $error("byte in discard phase produced a beat");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_COMMAND_LEN + 1))
      else $error("command letter count overran");

   a_disconnect_restarts: assert property (@(posedge clock) disable iff (reset)
      (advance && emit && emit_kind == EV_DISCONNECT) |=> phase_ff == PH_START)
      else $error("parser did not restart after disconnect");

   a_beat_from_byte: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(advance && emit))
      else $error("result beat appeared without a byte behind it");
`endif

endmodule

@@ bench/stomp_frame_header_parser_top_test.sv @@
`timescale 1ns / 1ps

module stomp_frame_header_parser_top_test;
   import stomp_fhp_pkg::*;

   localparam int HASH_W        = 32;
   localparam int NAME_W        = 12;
   localparam int VALUE_W       = 16;
   localparam int MAX_CMD_LEN   = 11;
   localparam int MIN_CMD_LEN   = 3;
   localparam int UNCHECKED_POS = 8;
   localparam int CMD_COUNT     = 15;
   localparam int RESET_CYCLES  = 12;
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_CYCLES  = 10;
   localparam int MAX_REPORTS   = 40;
   localparam int TIMEOUT_NS    = 20_000_000;

   typedef struct {
      event_type            kind;
      command_type          cmd;
      logic [HASH_W-1:0]    hash;
      logic [NAME_W-1:0]    name_len;
      logic [VALUE_W-1:0]   value_len;
      logic                 flagged;
   } parse_event_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [7:0]          req_data_byte = 8'h00;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [1:0]          rsp_event_kind;
   logic [3:0]          rsp_command_code;
   logic [HASH_W-1:0]   rsp_name_hash;
   logic [NAME_W-1:0]   rsp_name_length;
   logic [VALUE_W-1:0]  rsp_value_length;
   logic                rsp_name_flagged;

   string       cmd_words [CMD_COUNT] = '{"ACK", "NACK", "SEND", "STOMP", "BEGIN", "ABORT",
      "ERROR", "COMMIT", "CONNECT", "MESSAGE", "RECEIPT", "SUBSCRIBE", "CONNECTED",
      "DISCONNECT", "UNSUBSCRIBE"};
   command_type cmd_codes [CMD_COUNT] = '{CMD_ACK, CMD_NACK, CMD_SEND, CMD_CONNECT,
      CMD_BEGIN, CMD_ABORT, CMD_ERROR, CMD_COMMIT, CMD_CONNECT, CMD_MESSAGE, CMD_RECEIPT,
      CMD_SUBSCRIBE, CMD_CONNECTED, CMD_DISCONNECT, CMD_UNSUBSCRIBE};

   // Parser state as the bench expects it to be after each accepted byte.
   phase_type           phase = PH_START;
   logic [7:0]          letters [MAX_CMD_LEN];
   int                  letter_count = 0;
   command_type         frame_cmd = CMD_NONE;
   logic [HASH_W-1:0]   hash_acc = '0;
   logic [NAME_W-1:0]   name_count = '0;
   logic [VALUE_W-1:0]  value_count = '0;
   logic                name_odd = 1'b0;

   parse_event_type awaited_events [$];
   int           mismatches = 0;
   int           live_bytes = 0;
   int           send_idle_pct = 0;
   int           recv_stall_pct = 0;
   logic         rx_hold = 1'b0;
   event         start_hold;

   stomp_frame_header_parser_top #(
      .MAX_COMMAND_LEN (MAX_CMD_LEN),
      .HASH_BITS       (HASH_W),
      .NAME_LEN_BITS   (NAME_W),
      .VALUE_LEN_BITS  (VALUE_W)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_command_code (rsp_command_code),
      .rsp_name_hash    (rsp_name_hash),
      .rsp_name_length  (rsp_name_length),
      .rsp_value_length (rsp_value_length),
      .rsp_name_flagged (rsp_name_flagged)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      rsp_stall <= rx_hold || ($urandom_range(99) < recv_stall_pct);
   end

   // A long hold on the result side, so that the parser backs up into its input.
   initial forever begin
      @(start_hold);
      rx_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rx_hold <= 1'b0;
   end

   task automatic add_letter(input logic [7:0] ch);
      if (letter_count < MAX_CMD_LEN) letters[letter_count] = ch;
      if (letter_count <= MAX_CMD_LEN) letter_count++;
   endtask

   function automatic command_type lookup_command();
      command_type found;
      bit          same;
      found = CMD_NONE;
      for (int i = 0; i < CMD_COUNT; i++) begin
         if (found == CMD_NONE && cmd_words[i].len() == letter_count) begin
            same = 1'b1;
            for (int j = 0; j < letter_count; j++) begin
               if (letters[j] != cmd_words[i][j]) same = 1'b0;
            end
            if (same) found = cmd_codes[i];
         end
      end
      return found;
   endfunction

   task automatic parse_byte(input logic [7:0] ch);
      logic         fire, with_header, invalid, name_char, blank_ends;
      event_type    kind;
      command_type  code;
      parse_event_type ev;
      fire = 1'b0;
      with_header = 1'b0;
      invalid = 1'b0;
      kind = EV_HEADER;
      name_char = (ch >= CH_LO_A && ch <= CH_LO_Z) || (ch >= CH_UP_A && ch <= CH_UP_Z) ||
                  ch == CH_HYPHEN;
      blank_ends = (frame_cmd == CMD_SEND || frame_cmd == CMD_MESSAGE);
      case (phase)
         PH_START: begin
            if (ch != CH_CR && ch != CH_LF) begin
               letter_count = 0;
               frame_cmd = CMD_NONE;
               phase = PH_COMMAND;
               add_letter(ch);
            end
         end
         PH_COMMAND: begin
            code = (letter_count >= MIN_CMD_LEN) ? lookup_command() : CMD_NONE;
            if (code != CMD_NONE) begin
               frame_cmd = code;
               if (code == CMD_DISCONNECT) begin
                  phase = PH_START;
                  fire = 1'b1;
                  kind = EV_DISCONNECT;
               end else if (ch == CH_CR) begin
                  phase = PH_COMMAND_LF;
               end else if (ch == CH_LF) begin
                  phase = PH_HDR_START;
               end else if (ch == CH_UP_E && code == CMD_CONNECT) begin
                  add_letter(ch);
               end else begin
                  invalid = 1'b1;
               end
            end else if (letter_count > MAX_CMD_LEN) begin
               invalid = 1'b1;
            end else if (letter_count >= MIN_CMD_LEN && letter_count != UNCHECKED_POS &&
                         (ch < CH_UP_A || ch > CH_LO_Z)) begin
               invalid = 1'b1;
            end else begin
               add_letter(ch);
            end
         end
         PH_COMMAND_LF: begin
            if (ch == CH_LF) phase = PH_HDR_START;
            else if (ch != CH_CR) invalid = 1'b1;
         end
         PH_HDR_START: begin
            name_odd = 1'b0;
            if (ch == CH_CR) begin
               phase = PH_ALMOST_DONE;
            end else if (ch == CH_LF) begin
               if (blank_ends) begin
                  fire = 1'b1;
                  kind = EV_HDRS_END;
                  phase = PH_START;
               end else begin
                  phase = PH_ALMOST_DONE;
               end
            end else if (ch == CH_NUL || ch == CH_COLON) begin
               invalid = 1'b1;
            end else begin
               phase = PH_HDR_NAME;
               hash_acc = HASH_W'(ch);
               name_count = NAME_W'(1);
               value_count = '0;
            end
         end
         PH_HDR_NAME: begin
            if (name_char) begin
               hash_acc = hash_acc * 31 + ch;
               if (name_count != '1) name_count++;
            end else if (ch == CH_COLON) begin
               value_count = '0;
               phase = PH_HDR_VALUE;
            end else if (ch == CH_CR) begin
               value_count = '0;
               phase = PH_HDR_CR;
            end else if (ch == CH_LF) begin
               phase = PH_HDR_START;
            end else if (ch == CH_NUL) begin
               invalid = 1'b1;
            end else begin
               name_odd = 1'b1;
               if (name_count != '1) name_count++;
            end
         end
         PH_HDR_VALUE: begin
            if (ch == CH_CR) begin
               phase = PH_HDR_CR;
            end else if (ch == CH_LF) begin
               phase = PH_HDR_START;
               fire = 1'b1;
               with_header = 1'b1;
            end else if (ch == CH_NUL) begin
               invalid = 1'b1;
            end else if (value_count != '1) begin
               value_count++;
            end
         end
         PH_HDR_CR: begin
            if (ch == CH_LF) begin
               phase = PH_HDR_START;
               fire = 1'b1;
               with_header = 1'b1;
            end else if (ch != CH_CR) begin
               invalid = 1'b1;
            end
         end
         PH_ALMOST_DONE: begin
            if ((ch == CH_CR || ch == CH_LF) && blank_ends || ch == CH_NUL) begin
               fire = 1'b1;
               kind = EV_HDRS_END;
               phase = PH_START;
            end else if (ch != CH_CR && ch != CH_LF) begin
               invalid = 1'b1;
            end
         end
         PH_DISCARD: begin
            if (ch == CH_NUL) phase = PH_START;
         end
         default: invalid = 1'b1;
      endcase
      // A NUL that breaks the frame also ends it; anything else leaves bytes to throw away.
      if (invalid) begin
         fire = 1'b1;
         kind = EV_INVALID;
         phase = (ch == CH_NUL) ? PH_START : PH_DISCARD;
      end
      if (fire) begin
         ev.kind = kind;
         ev.cmd = frame_cmd;
         ev.hash = with_header ? hash_acc : '0;
         ev.name_len = with_header ? name_count : '0;
         ev.value_len = with_header ? value_count : '0;
         ev.flagged = with_header ? name_odd : 1'b0;
         awaited_events.push_back(ev);
      end
   endtask

   task automatic check_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
      end
   endtask

   always @(posedge clock) begin : event_check
      parse_event_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_events.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: event beat expected none actual kind %0d command %0d",
                        $time, rsp_event_kind, rsp_command_code);
         end else begin
            want = awaited_events.pop_front();
            check_field("event_kind", 32'(want.kind), 32'(rsp_event_kind));
            check_field("command_code", 32'(want.cmd), 32'(rsp_command_code));
            check_field("name_hash", 32'(want.hash), 32'(rsp_name_hash));
            check_field("name_length", 32'(want.name_len), 32'(rsp_name_length));
            check_field("value_length", 32'(want.value_len), 32'(rsp_value_length));
            check_field("name_flagged", 32'(want.flagged), 32'(rsp_name_flagged));
         end
      end
   end

   // Valid is only lowered for an idle cycle or when the stream pauses, never between
   // two beats that follow each other directly.
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (phase != PH_DISCARD) live_bytes++;
      parse_byte(b);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (awaited_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [7:0] name_letter();
      int r;
      r = $urandom_range(52);
      if (r < 26) return 8'(CH_LO_A + r);
      if (r < 52) return 8'(CH_UP_A + r - 26);
      return CH_HYPHEN;
   endfunction

   function automatic logic [7:0] text_byte(input bit allow_colon);
      logic [7:0] b;
      do begin
         b = 8'($urandom);
      end while (b == CH_CR || b == CH_LF || b == CH_NUL || (b == CH_COLON && !allow_colon));
      return b;
   endfunction

   task automatic test_each_command();
      for (int i = 0; i < CMD_COUNT; i++) begin
         send_text(cmd_words[i]);
         if (cmd_codes[i] == CMD_DISCONNECT) begin
            send_byte(8'($urandom));
         end else begin
            send_text("\n\n");
            if (cmd_codes[i] != CMD_SEND && cmd_codes[i] != CMD_MESSAGE) send_byte(CH_NUL);
         end
      end
   endtask

   task automatic test_command_edges();
      // Leading line breaks are skipped; the second and third letters are not range checked.
      send_text("\015\n");
      send_byte(8'hFF);
      send_byte(CH_NUL);
      send_byte(8'h80);
      send_byte(8'h40);
      send_byte(CH_NUL);
      send_text("ABz{");
      send_byte(CH_NUL);
      // The ninth letter is free, and a twelfth letter makes the next byte fatal.
      send_text("ABCDEFGH");
      send_byte(8'h01);
      send_text("xyz");
      send_byte(CH_NUL);
      send_text("CONNECTED\015\015\n\n");
      send_byte(CH_NUL);
      send_text("STOMP\015\n");
      send_byte(CH_NUL);
      send_text("STOMPE!q");
      send_byte(CH_NUL);
      send_text("CONNECTX");
      send_byte(CH_NUL);
      send_text("BEGIN\015x");
      send_byte(CH_NUL);
      send_text("DISCONNECTZ");
      send_text("ACK");
      send_byte(CH_NUL);
   endtask

   task automatic test_header_lines();
      send_text("SUBSCRIBE\n");
      send_byte(8'hFF);
      send_text("id:7\n");
      send_text("a_b-C:xy\015\n");
      send_text("dropped\n");
      send_text("nocolon\015\015\n");
      send_text("k:\n");
      send_text("\015\n\015");
      send_byte(CH_NUL);
      send_text("MESSAGE\nm:1\n\015\n");
      send_text("SEND\nab");
      send_byte(CH_NUL);
      send_text("SEND\n:v\n");
      send_byte(CH_NUL);
      send_text("SEND\nk:v");
      send_byte(CH_NUL);
      send_text("SEND\nk\015z");
      send_byte(CH_NUL);
      send_text("ACK\n\015z");
      send_byte(CH_NUL);
   endtask

   task automatic send_random_frame();
      int          pick;
      string       word;
      command_type code;
      pick = $urandom_range(CMD_COUNT - 1);
      word = cmd_words[pick];
      code = cmd_codes[pick];
      repeat ($urandom_range(2)) send_byte($urandom_range(1) ? CH_CR : CH_LF);
      if ($urandom_range(9) == 0)
         word[$urandom_range(word.len() - 1)] = 8'($urandom_range(1, 255));
      send_text(word);
      if (code == CMD_DISCONNECT) begin
         send_byte(8'($urandom));
         return;
      end
      case ($urandom_range(9))
         0: send_byte(8'($urandom));
         1, 2, 3: send_text("\015\n");
         4: send_text("\015\015\n");
         default: send_byte(CH_LF);
      endcase
      repeat ($urandom_range(4)) begin
         send_byte(text_byte(1'b0));
         repeat ($urandom_range(6))
            send_byte($urandom_range(11) == 0 ? 8'($urandom) : name_letter());
         case ($urandom_range(9))
            0: send_byte(CH_LF);
            1: send_text("\015\n");
            2: send_text("\015\015\n");
            default: begin
               send_byte(CH_COLON);
               repeat ($urandom_range(8)) send_byte(text_byte(1'b1));
               if ($urandom_range(1)) send_byte(CH_LF);
               else send_text("\015\n");
            end
         endcase
      end
      if ($urandom_range(1)) send_byte(CH_LF);
      else send_text("\015\n");
      if (code != CMD_SEND && code != CMD_MESSAGE) begin
         repeat ($urandom_range(2)) send_byte(CH_LF);
         send_byte($urandom_range(19) == 0 ? 8'($urandom) : CH_NUL);
      end
   endtask

   task automatic test_random_frames(input int count);
      int goal;
      goal = live_bytes + count;
      while (live_bytes < goal) begin
         if ($urandom_range(99) < 12) repeat ($urandom_range(1, 8)) send_byte(8'($urandom));
         else send_random_frame();
         // Finish off a broken frame so that the next one starts clean.
         if (phase == PH_DISCARD) begin
            repeat ($urandom_range(3)) send_byte(8'($urandom_range(1, 255)));
            send_byte(CH_NUL);
         end
      end
   endtask

   task automatic test_output_stall();
      -> start_hold;
      send_text("SEND\n");
      repeat (24) begin
         send_byte(name_letter());
         send_byte(CH_COLON);
         send_byte(text_byte(1'b1));
         send_byte(CH_LF);
      end
      send_byte(CH_LF);
      wait_drain();
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 26;
      recv_stall_pct = 57;
      test_each_command();
      test_command_edges();
      test_header_lines();
      test_random_frames(80);

      send_idle_pct = 57;
      recv_stall_pct = 26;
      test_random_frames(80);

      send_idle_pct = 0;
      recv_stall_pct = 0;
      test_output_stall();
      test_random_frames(40);

      wait_drain();
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Simulation FAILED");
      $finish;
   end

endmodule
